// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the masked A2B converter RTL.
// ASSERT_CLK expects i_clk and i_rst_n in scope; ASSERT_CLK_ALWAYS expects i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_CLK_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/ma2b_pkg.sv =====
// Types, constants and the per-bit carry gadget for the masked A2B converter.
// No dependencies.
`default_nettype none

package ma2b_pkg;

    localparam int WIDTH_DEF  = 8;   // adder width
    localparam int FIELD_W    = 8;   // width of every data field and configuration register
    localparam int CARRY_STEP = 2;   // carry rounds resolved per pipeline stage

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GADGET_RANDOM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REMASK_FIRST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMASK_SECOND = 2'd2;

    localparam logic [FIELD_W-1:0] GADGET_RANDOM_RST = 8'd1;
    localparam logic [FIELD_W-1:0] REMASK_FIRST_RST  = 8'd0;
    localparam logic [FIELD_W-1:0] REMASK_SECOND_RST = 8'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] first_share_a;
        logic [FIELD_W-1:0] first_share_b;
        logic [FIELD_W-1:0] second_share_a;
        logic [FIELD_W-1:0] second_share_b;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] sum_share_a;
        logic [FIELD_W-1:0] sum_share_b;
    } t_out_item;

    // One bit of one carry round: three ISW AND gadgets (x&y, x&c, y&c), all
    // using the same random bit, XORed together. Returns {share1, share0}.
    function automatic logic [1:0] carry_bits(
        input logic x0, input logic x1,
        input logic y0, input logic y1,
        input logic c0, input logic c1,
        input logic r
    );
        logic s0;
        logic s1;
        s0 = (x0 & y0) ^ (x0 & c0) ^ (y0 & c0) ^ r;
        s1 = (x1 & y1) ^ (x0 & y1) ^ (x1 & y0)
           ^ (x1 & c1) ^ (x0 & c1) ^ (x1 & c0)
           ^ (y1 & c1) ^ (y0 & c1) ^ (y1 & c0) ^ r;
        return {s1, s0};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/masked_arith_to_bool_converter.sv =====
// Masked arithmetic-to-Boolean converter, two shares per operand: top level.
// Depends on ma2b_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

// Takes one request (two Boolean-shared operands) per cycle when not stalled
// and returns two Boolean shares of their sum modulo 2^WIDTH. Both operands
// are remasked with the configured values, then added by a masked ripple
// adder whose ANDs are two-share ISW gadgets using the configured random
// word. The pipeline has one remask stage, one stage per two carry rounds
// of the ripple chain, and one output stage. Throughput is one request per
// cycle while the output is not stalled; a stall on the output backs up
// only as far as there are empty stages. Configuration writes must happen
// while the pipeline is empty.
module masked_arith_to_bool_converter #(
    parameter int WIDTH = ma2b_pkg::WIDTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  ma2b_pkg::t_in_item            i_data,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output ma2b_pkg::t_out_item                 o_data,
    input  wire                                 i_cfg_we,
    input  wire  [ma2b_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [ma2b_pkg::FIELD_W-1:0]        i_cfg_data
);

    localparam int FieldW    = ma2b_pkg::FIELD_W;
    localparam int Step      = ma2b_pkg::CARRY_STEP;
    localparam int Rounds    = WIDTH - 1;
    localparam int NumCarry  = (Rounds + Step - 1) / Step;
    localparam int NumStages = NumCarry + 2;
    localparam int MaxW      = (WIDTH > FieldW) ? WIDTH : FieldW;

    typedef struct packed {
        logic [WIDTH-1:0] x0;
        logic [WIDTH-1:0] x1;
        logic [WIDTH-1:0] y0;
        logic [WIDTH-1:0] y1;
        logic [WIDTH-1:0] c0;
        logic [WIDTH-1:0] c1;
    } t_work;

    // Configuration registers
    logic [FieldW-1:0] r_gadget_random;
    logic [FieldW-1:0] r_remask_first;
    logic [FieldW-1:0] r_remask_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gadget_random <= ma2b_pkg::GADGET_RANDOM_RST;
            r_remask_first  <= ma2b_pkg::REMASK_FIRST_RST;
            r_remask_second <= ma2b_pkg::REMASK_SECOND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ma2b_pkg::CFG_GADGET_RANDOM: r_gadget_random <= i_cfg_data;
                ma2b_pkg::CFG_REMASK_FIRST:  r_remask_first  <= i_cfg_data;
                ma2b_pkg::CFG_REMASK_SECOND: r_remask_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Fit 8-bit fields to the adder width (zero-extend or drop high bits)
    logic [MaxW-1:0]  ext_rnd, ext_m1, ext_m2;
    logic [MaxW-1:0]  ext_fa, ext_fb, ext_sa, ext_sb;
    logic [WIDTH-1:0] rnd_w, m1_w, m2_w;

    assign ext_rnd = MaxW'(r_gadget_random);
    assign ext_m1  = MaxW'(r_remask_first);
    assign ext_m2  = MaxW'(r_remask_second);
    assign ext_fa  = MaxW'(i_data.first_share_a);
    assign ext_fb  = MaxW'(i_data.first_share_b);
    assign ext_sa  = MaxW'(i_data.second_share_a);
    assign ext_sb  = MaxW'(i_data.second_share_b);
    assign rnd_w   = ext_rnd[WIDTH-1:0];
    assign m1_w    = ext_m1[WIDTH-1:0];
    assign m2_w    = ext_m2[WIDTH-1:0];

    // Pipeline flow control
    logic [NumStages-1:0] r_vld;
    logic [NumStages-1:0] vld_in;
    logic [NumStages-1:0] rdy;

    assign rdy[NumStages-1] = !r_vld[NumStages-1] || !i_stall;
    for (genvar k = 0; k < NumStages - 1; k++) begin : g_rdy
        assign rdy[k] = !r_vld[k] || rdy[k+1];
    end

    assign vld_in  = {r_vld[NumStages-2:0], i_valid};
    assign o_stall = !rdy[0];
    assign o_valid = r_vld[NumStages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (rdy & vld_in) | (~rdy & r_vld);
        end
    end

    // Stage outputs: index 0 is the remask stage, 1..NumCarry the carry stages
    wire t_work w_stage [NumCarry+1];

    // Remask stage
    t_work r_work0;
    t_work n_work0;

    always_comb begin
        n_work0.x0 = ext_fa[WIDTH-1:0] ^ m1_w;
        n_work0.x1 = ext_fb[WIDTH-1:0] ^ m1_w;
        n_work0.y0 = ext_sa[WIDTH-1:0] ^ m2_w;
        n_work0.y1 = ext_sb[WIDTH-1:0] ^ m2_w;
        n_work0.c0 = '0;
        n_work0.c1 = '0;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_work0 <= n_work0;
        end
    end

    assign w_stage[0] = r_work0;

    // Carry stages, each resolving up to Step ripple rounds
    for (genvar k = 1; k <= NumCarry; k++) begin : g_carry
        localparam int Base        = (k - 1) * Step;
        localparam int StageRounds = (Rounds - Base < Step) ? (Rounds - Base) : Step;

        t_work r_work;
        t_work n_work;

        always_comb begin
            n_work = w_stage[k-1];
            for (int s = 0; s < StageRounds; s++) begin
                {n_work.c1[Base+s+1], n_work.c0[Base+s+1]} = ma2b_pkg::carry_bits(
                    n_work.x0[Base+s], n_work.x1[Base+s],
                    n_work.y0[Base+s], n_work.y1[Base+s],
                    n_work.c0[Base+s], n_work.c1[Base+s],
                    rnd_w[Base+s]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (rdy[k] && r_vld[k-1]) begin
                r_work <= n_work;
            end
        end

        assign w_stage[k] = r_work;
    end

    // Output stage: z = x ^ y ^ c per share
    t_work               last_w;
    logic [WIDTH-1:0]    z0, z1;
    logic [MaxW-1:0]     ext_z0, ext_z1;
    ma2b_pkg::t_out_item r_out;

    assign last_w = w_stage[NumCarry];
    assign z0     = last_w.x0 ^ last_w.y0 ^ last_w.c0;
    assign z1     = last_w.x1 ^ last_w.y1 ^ last_w.c1;
    assign ext_z0 = MaxW'(z0);
    assign ext_z1 = MaxW'(z1);

    always_ff @(posedge i_clk) begin
        if (rdy[NumStages-1] && r_vld[NumStages-2]) begin
            r_out.sum_share_a <= ext_z0[FieldW-1:0];
            r_out.sum_share_b <= ext_z1[FieldW-1:0];
        end
    end

    assign o_data = r_out;

    // Checks
    `ASSERT_CLK_ALWAYS(a_empty_after_reset, !i_rst_n |=> (r_vld == '0),
        "pipeline not empty after reset")
    `ASSERT_CLK(a_stall_only_when_full, o_stall |-> (&r_vld),
        "input stalled while a stage is empty")
    `ASSERT_CLK(a_unmasked_sum, r_vld[NumCarry] |->
        ((z0 ^ z1) == WIDTH'((last_w.x0 ^ last_w.x1) + (last_w.y0 ^ last_w.y1))),
        "unmasked result is not the sum of the unmasked operands")

endmodule

`default_nettype wire

// ===== dv/tb_masked_arith_to_bool_converter.sv =====
// Self-checking testbench for masked_arith_to_bool_converter: random and corner
// requests, per-phase register settings and idle/stall patterns.
// Depends on ma2b_pkg and the RTL.
`default_nettype none

module tb_masked_arith_to_bool_converter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PHASES    = 8;
    localparam int REQS_PER_PHASE = 64;
    localparam int DRAIN_CYCLES   = 12;   // comfortably above the pipeline depth

    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_valid    = 1'b0;
    logic                           o_stall;
    ma2b_pkg::t_in_item             i_data     = '0;
    logic                           o_valid;
    logic                           i_stall    = 1'b0;
    ma2b_pkg::t_out_item            o_data;
    logic                           i_cfg_we   = 1'b0;
    logic [ma2b_pkg::CFG_IDX_W-1:0] i_cfg_idx  = ma2b_pkg::CFG_GADGET_RANDOM;
    logic [ma2b_pkg::FIELD_W-1:0]   i_cfg_data = '0;

    masked_arith_to_bool_converter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    ma2b_pkg::t_in_item  pending_reqs[$];
    ma2b_pkg::t_out_item expected_sums[$];
    int unsigned  reqs_queued   = 0;
    int unsigned  sums_checked  = 0;
    int unsigned  mismatches    = 0;
    int unsigned  send_idle_pct = 0;
    int unsigned  stall_pct     = 0;
    logic         req_taken     = 1'b0;

    // local copy of the configuration registers
    logic [ma2b_pkg::FIELD_W-1:0] gadget_word;
    logic [ma2b_pkg::FIELD_W-1:0] first_mask;
    logic [ma2b_pkg::FIELD_W-1:0] second_mask;

    // two-share ISW AND, returns {z1, z0}
    function automatic logic [2*ma2b_pkg::FIELD_W-1:0] isw_and(
        input logic [ma2b_pkg::FIELD_W-1:0] a0, input logic [ma2b_pkg::FIELD_W-1:0] a1,
        input logic [ma2b_pkg::FIELD_W-1:0] b0, input logic [ma2b_pkg::FIELD_W-1:0] b1,
        input logic [ma2b_pkg::FIELD_W-1:0] rnd
    );
        logic [ma2b_pkg::FIELD_W-1:0] z0;
        logic [ma2b_pkg::FIELD_W-1:0] z1;
        z0 = (a0 & b0) ^ rnd;
        z1 = (a1 & b1) ^ rnd ^ (a0 & b1) ^ (a1 & b0);
        return {z1, z0};
    endfunction

    function automatic ma2b_pkg::t_out_item predict_sum_shares(
        input ma2b_pkg::t_in_item req, input logic [ma2b_pkg::FIELD_W-1:0] rnd,
        input logic [ma2b_pkg::FIELD_W-1:0] m1, input logic [ma2b_pkg::FIELD_W-1:0] m2
    );
        logic [ma2b_pkg::FIELD_W-1:0]   x0, x1, y0, y1, c0, c1;
        logic [2*ma2b_pkg::FIELD_W-1:0] xy, xc, yc;
        ma2b_pkg::t_out_item            sum;
        x0 = req.first_share_a ^ m1;
        x1 = req.first_share_b ^ m1;
        y0 = req.second_share_a ^ m2;
        y1 = req.second_share_b ^ m2;
        c0 = '0;
        c1 = '0;
        for (int j = 0; j < ma2b_pkg::FIELD_W - 1; j++) begin
            xy = isw_and(x0, x1, y0, y1, rnd);
            xc = isw_and(x0, x1, c0, c1, rnd);
            yc = isw_and(y0, y1, c0, c1, rnd);
            c0[j+1] = xy[j] ^ xc[j] ^ yc[j];
            c1[j+1] = xy[ma2b_pkg::FIELD_W+j] ^ xc[ma2b_pkg::FIELD_W+j]
                    ^ yc[ma2b_pkg::FIELD_W+j];
        end
        sum.sum_share_a = x0 ^ y0 ^ c0;
        sum.sum_share_b = x1 ^ y1 ^ c1;
        return sum;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    // driver: new request only once the current one is gone
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || req_taken) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_data  <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor: predicts on request accept, checks on result accept
    always @(posedge i_clk) begin
        ma2b_pkg::t_out_item want;
        if (!i_rst_n) begin
            req_taken   <= 1'b0;
            gadget_word <= ma2b_pkg::GADGET_RANDOM_RST;
            first_mask  <= ma2b_pkg::REMASK_FIRST_RST;
            second_mask <= ma2b_pkg::REMASK_SECOND_RST;
        end else begin
            req_taken <= i_valid && !o_stall;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ma2b_pkg::CFG_GADGET_RANDOM: gadget_word <= i_cfg_data;
                    ma2b_pkg::CFG_REMASK_FIRST:  first_mask  <= i_cfg_data;
                    ma2b_pkg::CFG_REMASK_SECOND: second_mask <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !o_stall)
                expected_sums.push_back(
                    predict_sum_shares(i_data, gadget_word, first_mask, second_mask));
            if (o_valid && !i_stall) begin
                sums_checked++;
                if (expected_sums.size() == 0) begin
                    note_mismatch($sformatf("unexpected result a=%02h b=%02h",
                                            o_data.sum_share_a, o_data.sum_share_b));
                end else begin
                    want = expected_sums.pop_front();
                    if (o_data.sum_share_a !== want.sum_share_a)
                        note_mismatch($sformatf("sum_share_a exp %02h got %02h",
                                                want.sum_share_a, o_data.sum_share_a));
                    if (o_data.sum_share_b !== want.sum_share_b)
                        note_mismatch($sformatf("sum_share_b exp %02h got %02h",
                                                want.sum_share_b, o_data.sum_share_b));
                end
            end
        end
    end

    task automatic queue_req(input logic [7:0] fa, input logic [7:0] fb,
                             input logic [7:0] sa, input logic [7:0] sb);
        ma2b_pkg::t_in_item req;
        req.first_share_a  = fa;
        req.first_share_b  = fb;
        req.second_share_a = sa;
        req.second_share_b = sb;
        pending_reqs.push_back(req);
        reqs_queued++;
    endtask

    // operand values x and y, split with the given share masks
    task automatic queue_sum(input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] mx, input logic [7:0] my);
        queue_req(mx, mx ^ x, my, my ^ y);
    endtask

    task automatic write_reg(input logic [ma2b_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sums_checked != reqs_queued)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_operand();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] cfg_set[RAND_PHASES][3];
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset-value registers, operand and share corners
        queue_sum(8'h00, 8'h00, 8'h00, 8'h00);
        queue_sum(8'hFF, 8'h01, 8'h00, 8'h00);
        queue_sum(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_sum(8'h80, 8'h80, 8'h5A, 8'hA5);
        queue_sum(8'h7F, 8'h01, 8'h00, 8'hFF);
        queue_sum(8'hAA, 8'h55, 8'h33, 8'hCC);
        queue_sum(8'h55, 8'h55, 8'hFF, 8'h00);
        queue_sum(8'h01, 8'hFF, 8'h0F, 8'hF0);
        queue_sum(8'hFF, 8'h00, 8'h00, 8'h00);
        queue_sum(8'h00, 8'hFF, 8'hFF, 8'hFF);
        queue_req(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_req(8'h00, 8'hFF, 8'hFF, 8'h00);
        queue_req(8'hFF, 8'h00, 8'h00, 8'hFF);
        queue_req(8'h01, 8'h02, 8'h04, 8'h08);
        queue_req(8'h80, 8'h40, 8'h20, 8'h10);
        for (int k = 0; k < 6; k++)
            queue_req(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        wait_idle();

        // register settings per phase: extremes first, then random
        cfg_set[0] = '{8'h00, 8'h00, 8'h00};
        cfg_set[1] = '{8'hFF, 8'hFF, 8'hFF};
        cfg_set[2] = '{8'hAA, 8'h55, 8'hFF};
        cfg_set[3] = '{8'h00, 8'hFF, 8'h00};
        for (int p = 4; p < RAND_PHASES; p++)
            cfg_set[p] = '{8'($urandom), 8'($urandom), 8'($urandom)};

        for (int p = 0; p < RAND_PHASES; p++) begin
            write_reg(ma2b_pkg::CFG_GADGET_RANDOM, cfg_set[p][0]);
            write_reg(ma2b_pkg::CFG_REMASK_FIRST,  cfg_set[p][1]);
            write_reg(ma2b_pkg::CFG_REMASK_SECOND, cfg_set[p][2]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 77; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 77; end
                default: begin send_idle_pct = 11; stall_pct = 11; end
            endcase
            for (int k = 0; k < REQS_PER_PHASE; k++) begin
                if ($urandom_range(3) == 0)
                    queue_sum(pick_operand(), pick_operand(), 8'($urandom), 8'($urandom));
                else
                    queue_req(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
            wait_idle();
        end

        if (expected_sums.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", expected_sums.size()));
        if (mismatches == 0)
            $display("masked_arith_to_bool_converter test passed");
        else
            $display("masked_arith_to_bool_converter test failed");
        $finish;
    end

    initial begin
        #400_000;
        $display("masked_arith_to_bool_converter test failed");
        $finish;
    end

endmodule

`default_nettype wire
